[design/dlr_pkg.sv]
`default_nettype none
package dlr_pkg;

  localparam int unsigned Capacity   = 64;
  localparam int unsigned IdxW       = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW       = $clog2(Capacity + 1);
  localparam int unsigned LabelW     = 32;
  localparam int unsigned NewLabelW  = 6;
  localparam int unsigned ClassCntW  = 7;
  localparam int unsigned OutDataW   = 16;

  typedef enum logic [0:0] {
    REQ_RELABEL = 1'b0,
    REQ_CLEAR   = 1'b1
  } dlr_req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } dlr_state_e;

  // Table port request from the sequencer.
  typedef struct packed {
    logic              rd_en;
    logic [IdxW-1:0]   rd_addr;
    logic              wr_en;
    logic [IdxW-1:0]   wr_addr;
    logic [LabelW-1:0] wr_data;
  } dlr_tbl_req_t;

  // Finished result handed to the output register.
  typedef struct packed {
    logic                 valid;
    logic [NewLabelW-1:0] dense_idx;
    logic [ClassCntW-1:0] class_count;
    logic                 table_full;
  } dlr_result_t;

endpackage
`default_nettype wire

[design/dlr_table.sv]
`default_nettype none
module dlr_table (
  input  wire logic                       clk_i,
  input  wire dlr_pkg::dlr_tbl_req_t      req_i,
  output logic [dlr_pkg::LabelW-1:0]      rd_data_o
);
  import dlr_pkg::*;

  logic [LabelW-1:0] mem_q [Capacity];
  logic [LabelW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

[design/dlr_seq.sv]
`default_nettype none
module dlr_seq (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       in_req_i,
  input  wire logic [dlr_pkg::LabelW-1:0] in_label_i,
  input  wire logic [dlr_pkg::LabelW-1:0] rd_data_i,
  output dlr_pkg::dlr_tbl_req_t           tbl_req_o,
  input  wire logic                       out_free_i,
  output dlr_pkg::dlr_result_t            result_o
);
  import dlr_pkg::*;

  dlr_state_e        state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   ptr_q, ptr_d;
  logic              pend_q, pend_d;
  logic [IdxW-1:0]   pend_idx_q, pend_idx_d;
  logic [LabelW-1:0] label_q, label_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              full_q, full_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    pend_idx_q <= pend_idx_d;
    label_q    <= label_d;
    idx_q      <= idx_d;
    full_q     <= full_d;
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ptr_d      = ptr_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    label_d    = label_q;
    idx_d      = idx_q;
    full_d     = full_q;
    in_ready_o = 1'b0;
    tbl_req_o  = '0;
    tbl_req_o.wr_data = label_q;
    result_o   = '0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (dlr_req_e'(in_req_i) == REQ_CLEAR) begin
            cnt_d   = '0;
            idx_d   = '0;
            full_d  = 1'b0;
            state_d = ST_FINISH;
          end else begin
            label_d = in_label_i;
            ptr_d   = '0;
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        priority if (pend_q && (rd_data_i == label_q)) begin
          // hit on the entry read last cycle
          idx_d   = pend_idx_q;
          full_d  = 1'b0;
          state_d = ST_FINISH;
        end else if (ptr_q < cnt_q) begin
          // advance: read the next entry, compare it next cycle
          tbl_req_o.rd_en   = 1'b1;
          tbl_req_o.rd_addr = ptr_q[IdxW-1:0];
          ptr_d      = ptr_q + 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = ptr_q[IdxW-1:0];
        end else begin
          // miss: append when there is room, else flag overflow
          if (cnt_q < CntW'(Capacity)) begin
            tbl_req_o.wr_en   = 1'b1;
            tbl_req_o.wr_addr = cnt_q[IdxW-1:0];
            idx_d  = cnt_q[IdxW-1:0];
            cnt_d  = cnt_q + 1'b1;
            full_d = 1'b0;
          end else begin
            idx_d  = '0;
            full_d = 1'b1;
          end
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        result_o.valid       = 1'b1;
        result_o.dense_idx   = NewLabelW'(idx_q);
        result_o.class_count = ClassCntW'(cnt_q);
        result_o.table_full  = full_q;
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[design/dense_label_remapper.sv]
`default_nettype none
// Dense label remapper: maps 32-bit class labels to dense indices in order of
// first appearance. Each input transfer carries a label in s_axis_tdata_i and
// a request kind in s_axis_tuser_i (0 relabel, 1 clear). Each request yields
// exactly one output transfer with the dense index, the number of distinct
// labels held, and an overflow flag set when a new label found the table full
// (capacity Capacity from dlr_pkg, 64 entries). A relabel scans the table one
// entry per cycle through the single read port of the label memory, up to the
// number of labels held; a hit on an earlier entry ends the scan sooner. A
// clear skips the scan. The block takes one request at a time: s_axis_tready_o
// is high only while the sequencer is idle, but a finished result waiting in
// the output register does not keep it from taking the next request. The label
// memory needs no clearing after reset; only entries below the fill count are
// ever read.
module dense_label_remapper (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] label
  input  wire logic        s_axis_tuser_i,   // [0] req_type
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o    // [5:0] dense_idx, [12:6] class_count,
                                             // [13] table_full, [15:14] zero
);
  import dlr_pkg::*;

  dlr_tbl_req_t      tbl_req;
  logic [LabelW-1:0] rd_data;
  dlr_result_t       result;
  logic              out_free;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  // Search table: label memory with registered read.
  dlr_table u_table (
    .clk_i     (clk_i),
    .req_i     (tbl_req),
    .rd_data_o (rd_data)
  );

  // Sequencer: scans entries, appends new labels, keeps the fill count.
  dlr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_req_i   (s_axis_tuser_i),
    .in_label_i (s_axis_tdata_i),
    .rd_data_i  (rd_data),
    .tbl_req_o  (tbl_req),
    .out_free_i (out_free),
    .result_o   (result)
  );

  // Output register takes a new result once the held one has been transferred.
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= result.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && result.valid) begin
      out_data_q <= OutDataW'({result.table_full, result.class_count, result.dense_idx});
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
`default_nettype wire

[dv/dense_label_remapper_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the dense label remapper. Every accepted request
// runs through a local model of the first-seen table; the predicted index,
// count and overflow flag wait in a queue until the matching output transfer.
module dense_label_remapper_tb;
  import dlr_pkg::*;

  localparam int unsigned ItemsTarget  = 1850;
  localparam int unsigned IdlePct      = 22;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned StallLimit   = 2500;
  localparam int unsigned SettleCycles = 80;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned PoolDepth    = 96;

  // One predicted output transfer.
  typedef struct packed {
    logic [NewLabelW-1:0] idx;
    logic [ClassCntW-1:0] cnt;
    logic                 full;
  } remap_res_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              s_valid = 1'b0;
  logic [LabelW-1:0] s_label = '0;
  logic              s_kind = REQ_RELABEL;
  logic              m_ready = 1'b0;
  logic              s_axis_tready_o;
  logic              m_axis_tvalid_o;
  logic [15:0]       m_axis_tdata_o;

  // Local copy of the label table.
  logic [LabelW-1:0] first_seen_tbl [Capacity];
  int unsigned       held_cnt = 0;
  remap_res_t        pending_remaps [$];

  int unsigned fail_cnt = 0;
  int unsigned items_sent = 0;
  bit          idle_en = 1'b1;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned hold_ctr = 0;

  dense_label_remapper u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_label),
    .s_axis_tuser_i  (s_kind),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Apply one request to the local table and return the result it yields.
  function automatic remap_res_t remap_label(dlr_req_e kind, logic [LabelW-1:0] lab);
    remap_res_t  res;
    bit          hit;
    res = '0;
    hit = 1'b0;
    if (kind == REQ_CLEAR) begin
      held_cnt = 0;
    end else begin
      // Search in first-seen order; the earliest match wins.
      for (int unsigned i = 0; i < held_cnt; i++) begin
        if (!hit && first_seen_tbl[i] == lab) begin
          res.idx = NewLabelW'(i);
          hit     = 1'b1;
        end
      end
      if (!hit) begin
        if (held_cnt < Capacity) begin
          first_seen_tbl[held_cnt] = lab;
          res.idx  = NewLabelW'(held_cnt);
          held_cnt = held_cnt + 1;
        end else begin
          // Full table: drop the label and flag the overflow.
          res.full = 1'b1;
        end
      end
    end
    res.cnt = ClassCntW'(held_cnt);
    return res;
  endfunction

  task automatic note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= MaxReports) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // Offer one request, idling at random first, and record its prediction on transfer.
  task automatic send_req(input dlr_req_e kind, input logic [LabelW-1:0] lab);
    remap_res_t pred;
    while (idle_en && $urandom_range(99) < IdlePct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_kind  <= kind;
    s_label <= lab;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = remap_label(kind, lab);
    pending_remaps = {pending_remaps, pred};
    items_sent++;
  endtask

  // Drop valid and hold the sender until every outstanding result is back.
  task automatic wait_drained();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending_remaps.size() != 0);
  endtask

  task automatic test_directed();
    send_req(REQ_CLEAR, 32'h0000_0000);     // clear on an empty table
    send_req(REQ_RELABEL, 32'h0000_0000);
    send_req(REQ_RELABEL, 32'h7FFF_FFFF);
    send_req(REQ_RELABEL, 32'h8000_0000);
    send_req(REQ_RELABEL, 32'hFFFF_FFFF);
    send_req(REQ_RELABEL, 32'h0000_0000);   // known label, first entry
    send_req(REQ_RELABEL, 32'hFFFF_FFFF);   // known label, last entry
    send_req(REQ_RELABEL, 32'h0000_0001);
    send_req(REQ_RELABEL, 32'h8000_0000);
    send_req(REQ_CLEAR, 32'hFFFF_FFFF);     // label on a clear is ignored
    send_req(REQ_RELABEL, 32'h7FFF_FFFF);   // index restarts at zero
    send_req(REQ_RELABEL, 32'h7FFF_FFFF);
    send_req(REQ_RELABEL, 32'h5555_5555);
    send_req(REQ_RELABEL, 32'hAAAA_AAAA);
    send_req(REQ_CLEAR, 32'h1234_5678);
    send_req(REQ_CLEAR, 32'h0000_0000);     // back-to-back clears
    send_req(REQ_RELABEL, 32'hAAAA_AAAA);
    wait_drained();
  endtask

  // Fill the table, then offer new labels (overflow) and known ones (found).
  task automatic test_overflow();
    send_req(REQ_CLEAR, 32'h0);
    for (int unsigned i = 0; i < Capacity; i++) begin
      send_req(REQ_RELABEL, 32'h9E00_0000 + i * 7);
    end
    send_req(REQ_RELABEL, 32'hDEAD_0001);
    send_req(REQ_RELABEL, 32'h9E00_0000 + (Capacity - 1) * 7);
    send_req(REQ_RELABEL, 32'hDEAD_0001);
    send_req(REQ_RELABEL, 32'h9E00_0000);
    send_req(REQ_RELABEL, 32'hFFFF_FFFF);
    send_req(REQ_CLEAR, 32'h0);
    send_req(REQ_RELABEL, 32'hDEAD_0001);   // accepted again after the clear
    wait_drained();
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    logic [LabelW-1:0] few [4];
    foreach (few[i]) few[i] = $urandom();
    hold_asked++;
    for (int i = 0; i < 14; i++) begin
      send_req(REQ_RELABEL, few[$urandom_range(3)]);
    end
    wait_drained();
  endtask

  // Well-formed runs: a clear, then labels from a pool with repeats; a few
  // runs are large enough to overflow. Noise bursts mix clears at random.
  task automatic test_random();
    logic [LabelW-1:0] pool [PoolDepth];
    int unsigned       pool_sz;
    int unsigned       run_len;
    int unsigned       cursor;
    int unsigned       seq_no;
    int unsigned       pick;
    bit                wide;
    seq_no = 0;
    while (items_sent < ItemsTarget) begin
      seq_no++;
      // Keep a long stretch of runs free of idling on both sides.
      idle_en = (seq_no < 8 || seq_no > 16);
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(5, 25)) begin
          send_req(($urandom_range(3) == 0) ? REQ_CLEAR : REQ_RELABEL, $urandom());
        end
      end else begin
        wide    = ($urandom_range(99) < 15);
        pool_sz = wide ? $urandom_range(56, PoolDepth) : $urandom_range(1, 24);
        run_len = wide ? $urandom_range(80, 150) : $urandom_range(4, 40);
        for (int unsigned i = 0; i < pool_sz; i++) begin
          case ($urandom_range(9))
            0:       pool[i] = 32'h0000_0000;
            1:       pool[i] = 32'hFFFF_FFFF;
            2:       pool[i] = 32'h8000_0000;
            3:       pool[i] = 32'h7FFF_FFFF;
            // near miss: one bit away from the previous entry
            4:       pool[i] = (i == 0) ? $urandom() : pool[i-1] ^ (32'h1 << $urandom_range(31));
            default: pool[i] = $urandom();
          endcase
        end
        send_req(REQ_CLEAR, $urandom());
        cursor = 0;
        for (int unsigned n = 0; n < run_len; n++) begin
          if ($urandom_range(99) < 2) begin
            send_req(REQ_CLEAR, $urandom());      // broken run
          end else if (cursor < pool_sz && (cursor == 0 || $urandom_range(3) != 0)) begin
            send_req(REQ_RELABEL, pool[cursor]);
            cursor++;
          end else begin
            pick = $urandom_range(cursor - 1);
            send_req(REQ_RELABEL, pool[pick]);
          end
        end
      end
      if (seq_no % 4 == 0) begin
        wait_drained();
      end
    end
    idle_en = 1'b1;
  endtask

  // Receiver: random idling, with a counted hold-off when one is asked for.
  always @(posedge clk_i) begin
    if (hold_ctr != 0) begin
      hold_ctr <= hold_ctr - 1;
      m_ready  <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_ctr    <= HoldCycles;
      m_ready     <= 1'b0;
    end else begin
      m_ready <= !idle_en || ($urandom_range(99) >= IdlePct);
    end
  end

  // Compare each output transfer with the oldest prediction.
  always @(posedge clk_i) begin
    remap_res_t got;
    remap_res_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got.idx  = m_axis_tdata_o[5:0];
      got.cnt  = m_axis_tdata_o[12:6];
      got.full = m_axis_tdata_o[13];
      if (pending_remaps.size() == 0) begin
        note_fail($sformatf("unexpected result idx=%0d cnt=%0d full=%0b",
                            got.idx, got.cnt, got.full));
      end else begin
        want = pending_remaps.pop_front();
        if (got.idx != want.idx || got.cnt != want.cnt || got.full != want.full) begin
          note_fail($sformatf({"mismatch: expected idx=%0d cnt=%0d full=%0b, ",
                               "got idx=%0d cnt=%0d full=%0b"},
                              want.idx, want.cnt, want.full, got.idx, got.cnt, got.full));
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens on either side for too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_backpressure();
    test_random();
    wait_drained();
    // Leave room for any stray result after the last one expected.
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_remaps.size() != 0) begin
      note_fail($sformatf("%0d results never arrived", pending_remaps.size()));
    end
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
design/dlr_pkg.sv
design/dlr_table.sv
design/dlr_seq.sv
design/dense_label_remapper.sv
dv/dense_label_remapper_tb.sv
